[hw/rtl/bfd_pkg.sv]
// ----------------------------------------------------------------------------
// bfd_pkg
// Shared constants, register indexes and controller/datapath types of the
// box filter downscaler.
// ----------------------------------------------------------------------------
package bfd_pkg;

	localparam int PIX_W = 8;
	localparam int NUM_CH = 4;

	localparam int DEF_MAX_WIDTH = 4096;
	localparam int DEF_MAX_FACTOR = 16;
	localparam int DEF_CHANNELS = 4;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int WIDTH_FIELD_W = 13;
	localparam int HEIGHT_FIELD_W = 16;
	localparam int FACTOR_FIELD_W = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR = 2'd2;

	localparam int WIDTH_RST = 4096;
	localparam int HEIGHT_RST = 4096;
	localparam int FACTOR_RST = 2;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic acc;
		logic load_out;
	} bfd_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic keep;
		logic emit;
		logic div_done;
		logic out_free;
	} bfd_sts_t;

endpackage

[hw/rtl/bfd_if.sv]
// ----------------------------------------------------------------------------
// bfd_if
// Channel interfaces: input pixels, output pixels and register writes.
// ----------------------------------------------------------------------------
interface bfd_pix_if;
	logic valid;
	logic ready;
	logic [bfd_pkg::PIX_W-1:0] red_in;
	logic [bfd_pkg::PIX_W-1:0] green_in;
	logic [bfd_pkg::PIX_W-1:0] blue_in;
	logic [bfd_pkg::PIX_W-1:0] alpha_in;

	modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
	modport sink (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface bfd_res_if;
	logic valid;
	logic ready;
	logic [bfd_pkg::PIX_W-1:0] red_out;
	logic [bfd_pkg::PIX_W-1:0] green_out;
	logic [bfd_pkg::PIX_W-1:0] blue_out;
	logic [bfd_pkg::PIX_W-1:0] alpha_out;
	logic row_end;
	logic frame_end;

	modport source (output valid, red_out, green_out, blue_out, alpha_out, row_end,
		frame_end, input ready);
	modport sink (input valid, red_out, green_out, blue_out, alpha_out, row_end,
		frame_end, output ready);
endinterface

interface bfd_cfg_if;
	logic valid;
	logic ready;
	logic [bfd_pkg::CFG_IDX_W-1:0] index;
	logic [bfd_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/bfd_ram.sv]
// ----------------------------------------------------------------------------
// bfd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bfd_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/bfd_div.sv]
// ----------------------------------------------------------------------------
// bfd_div
// Restoring divider, one quotient bit per cycle on all channels at once.
// The quotient is known to fit in eight bits, so eight steps suffice.
// ----------------------------------------------------------------------------
module bfd_div #(
	parameter int CHANNELS = 4,
	parameter int SW = 16,
	parameter int DW = 9
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [CHANNELS*SW-1:0]              sums,
	input  logic [DW-1:0]                       divisor,
	output logic                                done,
	output logic [CHANNELS*bfd_pkg::PIX_W-1:0] quot
);
	import bfd_pkg::*;

	localparam int QSTEPS = PIX_W;
	localparam int CNT_W = $clog2(QSTEPS);
	localparam int DSW = DW + QSTEPS - 1;
	localparam int XW = (SW > DSW) ? SW : DSW;

	logic [DSW-1:0]   dsh_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(QSTEPS - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dsh_q <= {divisor, {(QSTEPS-1){1'b0}}};
		end else if (run_q) begin
			dsh_q <= dsh_q >> 1;
		end
	end

	for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
		logic [SW-1:0]    rem_q;
		logic [PIX_W-1:0] quot_q;
		logic [XW-1:0]    rem_x;
		logic [XW-1:0]    dsh_x;
		logic             ge;

		assign rem_x = XW'(rem_q);
		assign dsh_x = XW'(dsh_q);
		assign ge = rem_x >= dsh_x;

		always_ff @(posedge clk) begin
			if (start) begin
				rem_q <= sums[c*SW +: SW];
				quot_q <= '0;
			end else if (run_q) begin
				if (ge) begin
					rem_q <= SW'(rem_x - dsh_x);
				end
				quot_q <= {quot_q[PIX_W-2:0], ge};
			end
		end

		assign quot[c*PIX_W +: PIX_W] = quot_q;
	end

	assign done = done_q;

endmodule

[hw/rtl/bfd_dpath.sv]
// ----------------------------------------------------------------------------
// bfd_dpath
// Datapath: registers, raster position, column sum memory, accumulator,
// divider and output register.
// ----------------------------------------------------------------------------
module bfd_dpath #(
	parameter int MAX_WIDTH = 4096,
	parameter int MAX_FACTOR = 16,
	parameter int CHANNELS = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bfd_pkg::bfd_cmd_t              cmd,
	output bfd_pkg::bfd_sts_t              sts,
	input  logic [bfd_pkg::PIX_W-1:0]      red,
	input  logic [bfd_pkg::PIX_W-1:0]      green,
	input  logic [bfd_pkg::PIX_W-1:0]      blue,
	input  logic [bfd_pkg::PIX_W-1:0]      alpha,
	input  logic                           cfg_we,
	input  logic [bfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bfd_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [bfd_pkg::PIX_W-1:0]      red_o,
	output logic [bfd_pkg::PIX_W-1:0]      green_o,
	output logic [bfd_pkg::PIX_W-1:0]      blue_o,
	output logic [bfd_pkg::PIX_W-1:0]      alpha_o,
	output logic                           row_end_o,
	output logic                           frame_end_o
);
	import bfd_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int FW = $clog2(MAX_FACTOR + 1);
	localparam int BW = $clog2(MAX_FACTOR);
	localparam int SW = $clog2(255 * MAX_FACTOR * MAX_FACTOR + 1);
	localparam int DW = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
	localparam int MEM_W = CHANNELS * SW;
	localparam int W_RST = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;
	localparam int F_RST = (FACTOR_RST > MAX_FACTOR) ? MAX_FACTOR : FACTOR_RST;

	// effective register values
	logic [WW-1:0] w_q;
	logic [15:0]   h_q;
	logic [FW-1:0] f_q;
	logic [DW-1:0] ff_q;

	// raster position
	logic [CW-1:0] col_q;
	logic [CW-1:0] bcol_q;
	logic [15:0]   row_q;
	logic [BW-1:0] rib_q;
	logic [BW-1:0] ibx_q;

	logic [PIX_W-1:0] pix_c [NUM_CH];
	logic [PIX_W-1:0] pix_q [NUM_CH];
	logic             first_q;
	logic             emit_q;
	logic             rend_q;
	logic             fend_q;
	logic [CW-1:0]    addr_q;

	logic [31:0] w_new;
	logic [31:0] h_new;
	logic [31:0] f_new;
	logic [31:0] w32;
	logic [31:0] h32;
	logic [31:0] f32;
	logic [31:0] xs;
	logic [31:0] ys;
	logic        keep_c;
	logic        first_c;
	logic        emit_c;
	logic        last_x_c;
	logic        last_y_c;
	logic        col_wrap;
	logic        row_wrap;
	logic        ibx_wrap;
	logic        rib_wrap;

	logic [2*FW-1:0]              ff_c;
	logic [MEM_W-1:0]             rd_data;
	logic [MEM_W-1:0]             wr_data;
	logic [CHANNELS*PIX_W-1:0]    quot;
	logic                         div_done;
	logic [PIX_W-1:0]             res_c [NUM_CH];
	logic [PIX_W-1:0]             out_q [NUM_CH];
	logic                         out_valid_q;
	logic                         row_end_q;
	logic                         frame_end_q;

	// zero reads as one, oversize saturates
	always_comb begin
		w_new = 32'(cfg_data[WIDTH_FIELD_W-1:0]);
		if (w_new == 32'd0) begin
			w_new = 32'd1;
		end else if (w_new > 32'(MAX_WIDTH)) begin
			w_new = 32'(MAX_WIDTH);
		end
		h_new = 32'(cfg_data[HEIGHT_FIELD_W-1:0]);
		if (h_new == 32'd0) begin
			h_new = 32'd1;
		end
		f_new = 32'(cfg_data[FACTOR_FIELD_W-1:0]);
		if (f_new == 32'd0) begin
			f_new = 32'd1;
		end else if (f_new > 32'(MAX_FACTOR)) begin
			f_new = 32'(MAX_FACTOR);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= WW'(W_RST);
			h_q <= 16'(HEIGHT_RST);
			f_q <= FW'(F_RST);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:  w_q <= WW'(w_new);
				CFG_FRAME_HEIGHT: h_q <= 16'(h_new);
				CFG_SCALE_FACTOR: f_q <= FW'(f_new);
				default: ;
			endcase
		end
	end

	assign ff_c = {{FW{1'b0}}, f_q} * {{FW{1'b0}}, f_q};

	always_ff @(posedge clk) begin
		ff_q <= DW'(ff_c);
	end

	// block fit and position flags for the pixel at the current position
	always_comb begin
		w32 = 32'(w_q);
		h32 = 32'(h_q);
		f32 = 32'(f_q);
		xs = 32'(col_q) - 32'(ibx_q);
		ys = 32'(row_q) - 32'(rib_q);
		keep_c = (xs + f32 <= w32) && (ys + f32 <= h32);
		first_c = (rib_q == '0) && (ibx_q == '0);
		emit_c = (32'(rib_q) == f32 - 32'd1) && (32'(ibx_q) == f32 - 32'd1);
		last_x_c = xs + f32 + f32 > w32;
		last_y_c = ys + f32 + f32 > h32;
		col_wrap = 32'(col_q) + 32'd1 >= w32;
		row_wrap = 32'(row_q) + 32'd1 >= h32;
		ibx_wrap = 32'(ibx_q) + 32'd1 >= f32;
		rib_wrap = 32'(rib_q) + 32'd1 >= f32;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			bcol_q <= '0;
			row_q <= '0;
			rib_q <= '0;
			ibx_q <= '0;
		end else if (cfg_we) begin
			// any register write restarts the frame
			if (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT ||
				cfg_index == CFG_SCALE_FACTOR) begin
				col_q <= '0;
				bcol_q <= '0;
				row_q <= '0;
				rib_q <= '0;
				ibx_q <= '0;
			end
		end else if (cmd.take) begin
			if (col_wrap) begin
				col_q <= '0;
				bcol_q <= '0;
				ibx_q <= '0;
				if (row_wrap) begin
					row_q <= '0;
					rib_q <= '0;
				end else begin
					row_q <= row_q + 16'd1;
					rib_q <= rib_wrap ? '0 : rib_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
				if (ibx_wrap) begin
					ibx_q <= '0;
					bcol_q <= bcol_q + 1'b1;
				end else begin
					ibx_q <= ibx_q + 1'b1;
				end
			end
		end
	end

	assign pix_c[0] = red;
	assign pix_c[1] = green;
	assign pix_c[2] = blue;
	assign pix_c[3] = alpha;

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			pix_q <= pix_c;
			first_q <= first_c;
			emit_q <= emit_c;
			rend_q <= last_x_c;
			fend_q <= last_x_c && last_y_c;
			addr_q <= bcol_q;
		end
	end

	bfd_ram #(
		.WIDTH(MEM_W),
		.DEPTH(MAX_WIDTH)
	) u_sums (
		.clk  (clk),
		.we   (cmd.acc),
		.waddr(addr_q),
		.wdata(wr_data),
		.raddr(bcol_q),
		.rdata(rd_data)
	);

	// first pixel of a block loads the sum, the rest add to it
	for (genvar c = 0; c < CHANNELS; c++) begin : g_acc
		assign wr_data[c*SW +: SW] = first_q ? SW'(pix_q[c]) :
			rd_data[c*SW +: SW] + SW'(pix_q[c]);
	end

	bfd_div #(
		.CHANNELS(CHANNELS),
		.SW      (SW),
		.DW      (DW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.acc && emit_q),
		.sums   (wr_data),
		.divisor(ff_q),
		.done   (div_done),
		.quot   (quot)
	);

	for (genvar c = 0; c < NUM_CH; c++) begin : g_res
		if (c < CHANNELS) begin : g_on
			assign res_c[c] = quot[c*PIX_W +: PIX_W];
		end else begin : g_off
			assign res_c[c] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q <= res_c;
			row_end_q <= rend_q;
			frame_end_q <= fend_q;
		end
	end

	assign sts.keep = keep_c;
	assign sts.emit = emit_q;
	assign sts.div_done = div_done;
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign red_o = out_q[0];
	assign green_o = out_q[1];
	assign blue_o = out_q[2];
	assign alpha_o = out_q[3];
	assign row_end_o = row_end_q;
	assign frame_end_o = frame_end_q;

endmodule

[hw/rtl/bfd_ctrl.sv]
// ----------------------------------------------------------------------------
// bfd_ctrl
// Controller: takes one pixel at a time, sequences the sum update, the
// division and the hand-off to the output register.
// ----------------------------------------------------------------------------
module bfd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bfd_pkg::bfd_sts_t sts,
	output bfd_pkg::bfd_cmd_t cmd
);
	import bfd_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ACC,
		S_DIV,
		S_HOLD
	} state_t;

	state_t state_q;
	logic   ready_q;

	always_comb begin
		cmd.take = in_valid && ready_q;
		cmd.acc = (state_q == S_ACC);
		cmd.load_out = sts.out_free &&
			(((state_q == S_DIV) && sts.div_done) || (state_q == S_HOLD));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					// pixels outside any whole block only move the position
					if (cmd.take && sts.keep) begin
						state_q <= S_ACC;
						ready_q <= 1'b0;
					end
				end
				S_ACC: begin
					if (sts.emit) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				S_DIV: begin
					if (sts.div_done) begin
						if (sts.out_free) begin
							state_q <= S_IDLE;
							ready_q <= 1'b1;
						end else begin
							state_q <= S_HOLD;
						end
					end
				end
				S_HOLD: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign in_ready = ready_q;

endmodule

[hw/rtl/box_filter_image_downscaler.sv]
// ----------------------------------------------------------------------------
// box_filter_image_downscaler
// Integer box filter downscaler for RGBA8 frames in raster order.
// ----------------------------------------------------------------------------
// Pixels enter on pix, one transaction per pixel, in raster order. Each
// output pixel on res is the per-channel truncated mean of one factor by
// factor block; row_end marks the last block of an output row and
// frame_end the last block of the frame. Columns and rows past the last
// whole block are consumed and dropped.
// Registers (frame_width, frame_height, scale_factor) are written on cfg;
// the user must write them only while no pixel is in flight, which the
// block does not enforce. Every register write restarts the frame position.
// One pixel is worked on at a time: a pixel outside any kept block only
// moves the position, a pixel added to a column sum waits for the sum
// memory read, then write back, and the pixel that completes a block also
// runs the 8-step divider by factor squared. Results sit in an output
// register; a stalled receiver only holds the block once a second result
// is ready to be loaded. Reset returns the registers to 4096 x 4096 with
// factor 2 and the position to the top-left pixel; column sums are not
// cleared, each block's sum is loaded by its first pixel.
// ----------------------------------------------------------------------------
module box_filter_image_downscaler #(
	parameter int MAX_WIDTH = bfd_pkg::DEF_MAX_WIDTH,
	parameter int MAX_FACTOR = bfd_pkg::DEF_MAX_FACTOR,
	parameter int CHANNELS = bfd_pkg::DEF_CHANNELS
) (
	input  logic        clk,
	input  logic        arst_n,
	bfd_pix_if.sink     pix,
	bfd_res_if.source   res,
	bfd_cfg_if.sink     cfg
);
	import bfd_pkg::*;

	bfd_cmd_t cmd;
	bfd_sts_t sts;
	logic     cfg_we;

	assign cfg.ready = 1'b1;
	assign cfg_we = cfg.valid;

	bfd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(pix.valid),
		.in_ready(pix.ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	bfd_dpath #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_FACTOR(MAX_FACTOR),
		.CHANNELS  (CHANNELS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.red        (pix.red_in),
		.green      (pix.green_in),
		.blue       (pix.blue_in),
		.alpha      (pix.alpha_in),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.out_valid  (res.valid),
		.out_ready  (res.ready),
		.red_o      (res.red_out),
		.green_o    (res.green_out),
		.blue_o     (res.blue_out),
		.alpha_o    (res.alpha_out),
		.row_end_o  (res.row_end),
		.frame_end_o(res.frame_end)
	);

endmodule
